[src/sem_wq_pkg.sv]
// Package with opcodes, status codes and sequencer states for the semaphore wait table.
`timescale 1ns / 1ps
`default_nettype none
package sem_wq_pkg;

    // Operation codes carried by the kind field.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_OUT    = 2'd2,
        OP_HEAD   = 2'd3
    } op_t;

    // Status codes returned with every result word.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_WALK,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

[src/semaphore_wait_queue_table_top.sv]
// Top level: semaphore wait table with a sequenced descriptor scan and queue walk.
// Insert, remove and head scan every descriptor, one descriptor compared per cycle by a single
// key comparator, then decide and write the result word; out skips the scan and follows one
// queue link per cycle until the process is found or the walk misses.
// busy stays high until the result cycle ends, so a new command is taken at the earliest
// in the cycle after the result. The receiver cannot stall.
// Reset (rst_n low, asynchronous) clears all descriptor and process valid bits.
`timescale 1ns / 1ps
`default_nettype none
module semaphore_wait_queue_table_top #(
    parameter int MAX_PROCS = 20,
    parameter int ADDR_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [30:0] sem_addr,
    input  wire logic [4:0]  proc_id,
    output logic             done,
    output logic [4:0]       proc_out,
    output logic             proc_valid,
    output logic [1:0]       status
);
    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);

    // Table storage.
    logic [ADDR_BITS-1:0] key_reg   [MAX_PROCS];
    logic [IW-1:0]        first_reg [MAX_PROCS];
    logic [IW-1:0]        last_reg  [MAX_PROCS];
    logic [CW-1:0]        len_reg   [MAX_PROCS];
    logic [IW-1:0]        link_reg  [MAX_PROCS];
    logic [IW-1:0]        pdesc_reg [MAX_PROCS];
    logic [MAX_PROCS-1:0] used_reg, wait_reg;

    // Command and sequencer registers.
    sem_wq_pkg::state_t   state_reg, state_next;
    sem_wq_pkg::op_t      op_reg;
    logic [ADDR_BITS-1:0] key_in_reg;
    logic [4:0]           pid_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 hit_reg, free_ok_reg;
    logic [IW-1:0]        hit_idx_reg, free_idx_reg, cur_reg, prev_reg, desc_reg;
    logic                 has_prev_reg;
    logic [CW-1:0]        step_reg;
    logic                 done_reg, pvalid_reg;
    logic [4:0]           pout_reg;
    sem_wq_pkg::status_t  stat_reg;

    logic [IW-1:0] ci;
    logic          key_eq;
    logic          pid_ok;
    logic          walk_miss;
    logic          walk_hit;
    assign ci     = cnt_reg[IW-1:0];
    assign key_eq = (key_reg[ci] == key_in_reg);
    assign pid_ok = ({3'd0, pid_reg} < 8'(MAX_PROCS));

    // The walk ends on a miss (bad or idle process, or queue exhausted) or on a hit.
    assign walk_miss = !pid_ok || !wait_reg[pid_reg[IW-1:0]] || !used_reg[desc_reg] ||
                       (step_reg >= len_reg[desc_reg]);
    assign walk_hit  = (cur_reg == pid_reg[IW-1:0]);

    assign busy       = (state_reg != sem_wq_pkg::S_IDLE);
    assign done       = done_reg;
    assign proc_out   = pout_reg;
    assign proc_valid = pvalid_reg;
    assign status     = stat_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sem_wq_pkg::S_IDLE:
                if (start) state_next = sem_wq_pkg::S_SCAN;
            sem_wq_pkg::S_SCAN:
                if (op_reg == sem_wq_pkg::OP_OUT) state_next = sem_wq_pkg::S_WALK;
                else if (cnt_reg == CW'(MAX_PROCS - 1)) state_next = sem_wq_pkg::S_DECIDE;
            sem_wq_pkg::S_DECIDE: state_next = sem_wq_pkg::S_DONE;
            sem_wq_pkg::S_WALK:
                if (walk_miss || walk_hit)
                    state_next = sem_wq_pkg::S_DONE;
            sem_wq_pkg::S_DONE: state_next = sem_wq_pkg::S_IDLE;
            default: state_next = sem_wq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sem_wq_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath: scan, decide, walk, and result word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            wait_reg   <= '0;
            done_reg   <= 1'b0;
            for (int i = 0; i < MAX_PROCS; i++) len_reg[i] <= '0;
        end
        else
        begin
            // The strobe marks the cycle right after a decision or the end of a walk.
            done_reg <= (state_reg == sem_wq_pkg::S_DECIDE) ||
                        ((state_reg == sem_wq_pkg::S_WALK) && (walk_miss || walk_hit));
            case (state_reg)
                sem_wq_pkg::S_IDLE:
                    if (start)
                    begin
                        op_reg       <= sem_wq_pkg::op_t'(kind);
                        key_in_reg   <= ADDR_BITS'({33'd0, sem_addr});
                        pid_reg      <= proc_id;
                        cnt_reg      <= '0;
                        hit_reg      <= 1'b0;
                        free_ok_reg  <= 1'b0;
                    end
                sem_wq_pkg::S_SCAN:
                begin
                    // One descriptor compared per cycle.
                    if (used_reg[ci] && key_eq && !hit_reg)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= ci;
                    end
                    if (!used_reg[ci] && !free_ok_reg)
                    begin
                        free_ok_reg  <= 1'b1;
                        free_idx_reg <= ci;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (op_reg == sem_wq_pkg::OP_OUT)
                    begin
                        // Set up the queue walk for a given process.
                        desc_reg     <= pdesc_reg[pid_reg[IW-1:0]];
                        cur_reg      <= first_reg[pdesc_reg[pid_reg[IW-1:0]]];
                        has_prev_reg <= 1'b0;
                        step_reg     <= '0;
                    end
                end
                sem_wq_pkg::S_DECIDE:
                begin
                    case (op_reg)
                        sem_wq_pkg::OP_INSERT:
                        begin
                            pout_reg <= pid_reg;
                            if (pid_ok && !wait_reg[pid_reg[IW-1:0]])
                            begin
                                if (hit_reg)
                                begin
                                    if (len_reg[hit_idx_reg] == '0)
                                        first_reg[hit_idx_reg] <= pid_reg[IW-1:0];
                                    else
                                        link_reg[last_reg[hit_idx_reg]] <= pid_reg[IW-1:0];
                                    last_reg[hit_idx_reg] <= pid_reg[IW-1:0];
                                    len_reg[hit_idx_reg]  <= len_reg[hit_idx_reg] + 1'b1;
                                    pdesc_reg[pid_reg[IW-1:0]] <= hit_idx_reg;
                                    wait_reg[pid_reg[IW-1:0]]  <= 1'b1;
                                    pvalid_reg <= 1'b1; stat_reg <= sem_wq_pkg::ST_OK;
                                end
                                else if (free_ok_reg)
                                begin
                                    used_reg[free_idx_reg]  <= 1'b1;
                                    key_reg[free_idx_reg]   <= key_in_reg;
                                    first_reg[free_idx_reg] <= pid_reg[IW-1:0];
                                    last_reg[free_idx_reg]  <= pid_reg[IW-1:0];
                                    len_reg[free_idx_reg]   <= CW'(1);
                                    pdesc_reg[pid_reg[IW-1:0]] <= free_idx_reg;
                                    wait_reg[pid_reg[IW-1:0]]  <= 1'b1;
                                    pvalid_reg <= 1'b1; stat_reg <= sem_wq_pkg::ST_OK;
                                end
                                else
                                begin
                                    pvalid_reg <= 1'b0; stat_reg <= sem_wq_pkg::ST_FULL;
                                end
                            end
                            else
                            begin
                                pvalid_reg <= 1'b0; stat_reg <= sem_wq_pkg::ST_MISS;
                            end
                        end
                        sem_wq_pkg::OP_REMOVE:
                            if (hit_reg && len_reg[hit_idx_reg] != '0)
                            begin
                                len_reg[hit_idx_reg] <= len_reg[hit_idx_reg] - 1'b1;
                                if (len_reg[hit_idx_reg] == CW'(1))
                                    used_reg[hit_idx_reg] <= 1'b0;
                                else
                                    first_reg[hit_idx_reg] <= link_reg[first_reg[hit_idx_reg]];
                                wait_reg[first_reg[hit_idx_reg]] <= 1'b0;
                                pout_reg   <= 5'(first_reg[hit_idx_reg]);
                                pvalid_reg <= 1'b1; stat_reg <= sem_wq_pkg::ST_OK;
                            end
                            else
                            begin
                                pout_reg <= 5'd0; pvalid_reg <= 1'b0;
                                stat_reg <= sem_wq_pkg::ST_MISS;
                            end
                        sem_wq_pkg::OP_HEAD:
                            if (hit_reg && len_reg[hit_idx_reg] != '0)
                            begin
                                pout_reg   <= 5'(first_reg[hit_idx_reg]);
                                pvalid_reg <= 1'b1; stat_reg <= sem_wq_pkg::ST_OK;
                            end
                            else
                            begin
                                pout_reg <= 5'd0; pvalid_reg <= 1'b0;
                                stat_reg <= sem_wq_pkg::ST_MISS;
                            end
                        default:
                        begin
                            pout_reg <= 5'd0; pvalid_reg <= 1'b0;
                            stat_reg <= sem_wq_pkg::ST_MISS;
                        end
                    endcase
                end
                sem_wq_pkg::S_WALK:
                begin
                    // Follow one link per cycle until the process is found or the walk misses.
                    if (walk_miss)
                    begin
                        pout_reg <= 5'd0; pvalid_reg <= 1'b0;
                        stat_reg <= sem_wq_pkg::ST_MISS;
                        step_reg <= len_reg[desc_reg];
                    end
                    else if (walk_hit)
                    begin
                        if (!has_prev_reg)
                            first_reg[desc_reg] <= link_reg[cur_reg];
                        else
                            link_reg[prev_reg] <= link_reg[cur_reg];
                        if (last_reg[desc_reg] == cur_reg && has_prev_reg)
                            last_reg[desc_reg] <= prev_reg;
                        len_reg[desc_reg] <= len_reg[desc_reg] - 1'b1;
                        if (len_reg[desc_reg] == CW'(1))
                            used_reg[desc_reg] <= 1'b0;
                        wait_reg[cur_reg] <= 1'b0;
                        pout_reg <= pid_reg; pvalid_reg <= 1'b1;
                        stat_reg <= sem_wq_pkg::ST_OK;
                    end
                    else
                    begin
                        prev_reg     <= cur_reg;
                        has_prev_reg <= 1'b1;
                        cur_reg      <= link_reg[cur_reg];
                        step_reg     <= step_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // A result word appears only while a command is being finished.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("result without command");
    // A successful result always carries a real process.
    a_ok_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == sem_wq_pkg::ST_OK) |-> proc_valid) else $error("ok without process");
    // The block returns to idle right after a result.
    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("busy after result");
`endif
endmodule
`default_nettype wire
